FILE: rtl/mdt_pkg.sv
// shared types and constants of the dependency file tokenizer
package mdt_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [7:0] {
      PH_LEAD     = 8'b0000_0001,
      PH_TGT      = 8'b0000_0010,
      PH_TGT_SKIP = 8'b0000_0100,
      PH_AFTER    = 8'b0000_1000,
      PH_GAP      = 8'b0001_0000,
      PH_DEP      = 8'b0010_0000,
      PH_DEP_SKIP = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ESC_NONE   = 3'b001,
      ESC_BSL    = 3'b010,
      ESC_BSL_CR = 3'b100
   } esc_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_EMPTY     = 2'd1,
      ERR_NO_TARGET = 2'd2
   } err_type;

   typedef struct packed {
      logic       last_of_run;
      err_type    error_code;
      logic       is_target;
      kind_type   record_kind;
      logic [7:0] path_byte;
   } rec_type;

   typedef struct packed {
      phase_type phase;
      esc_type   esc;
      logic      path_nonempty;
   } state_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]      count;
      rec_type [MAX_RESULTS-1:0] recs;
   } step_type;

endpackage

FILE: rtl/mdt_step.sv
// per-byte tokenizer transition: next state and the records of one input beat
module mdt_step (
   input  mdt_pkg::state_type state_cur,
   input  logic [7:0]         text_byte,
   input  logic               byte_present,
   input  logic               content_end,
   output mdt_pkg::state_type state_nxt,
   output mdt_pkg::step_type  step_out
);
   import mdt_pkg::*;

   typedef struct packed {
      state_type st;
      step_type  res;
   } ctx_type;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_eol(logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic ctx_type emit(ctx_type x, kind_type k, logic [7:0] b, logic t,
                                    err_type e);
      ctx_type y;
      y = x;
      if (y.res.count < RES_CNT_W'(MAX_RESULTS)) begin
         y.res.recs[y.res.count[RES_CNT_W-2:0]].record_kind = k;
         y.res.recs[y.res.count[RES_CNT_W-2:0]].path_byte   = b;
         y.res.recs[y.res.count[RES_CNT_W-2:0]].is_target   = t;
         y.res.recs[y.res.count[RES_CNT_W-2:0]].error_code  = e;
         y.res.recs[y.res.count[RES_CNT_W-2:0]].last_of_run = 1'b0;
         y.res.count = y.res.count + RES_CNT_W'(1);
      end
      return y;
   endfunction

   function automatic ctx_type put_byte(ctx_type x, logic [7:0] c);
      ctx_type y;
      y = x;
      if (y.st.phase == PH_GAP) y.st.phase = PH_DEP;
      y = emit(y, KIND_BYTE, c, y.st.phase == PH_TGT, ERR_NONE);
      y.st.path_nonempty = 1'b1;
      return y;
   endfunction

   function automatic ctx_type stop_with(ctx_type x, kind_type k, err_type e);
      ctx_type y;
      y = emit(x, k, 8'd0, 1'b0, e);
      y.st.phase         = PH_DONE;
      y.st.esc           = ESC_NONE;
      y.st.path_nonempty = 1'b0;
      return y;
   endfunction

   // unescaped line end or end of content
   function automatic ctx_type finish_line(ctx_type x);
      ctx_type y;
      y = x;
      unique case (y.st.phase) inside
         PH_LEAD: y = stop_with(y, KIND_ERR, ERR_EMPTY);
         PH_TGT, PH_TGT_SKIP: begin
            if (!y.st.path_nonempty) begin
               y = stop_with(y, KIND_ERR, ERR_NO_TARGET);
            end else begin
               y = emit(y, KIND_END, 8'd0, 1'b1, ERR_NONE);
               y = stop_with(y, KIND_DONE, ERR_NONE);
            end
         end
         PH_DEP, PH_DEP_SKIP: begin
            y = emit(y, KIND_END, 8'd0, 1'b0, ERR_NONE);
            y = stop_with(y, KIND_DONE, ERR_NONE);
         end
         PH_AFTER, PH_GAP: y = stop_with(y, KIND_DONE, ERR_NONE);
         default: begin
            y.st.phase         = PH_DONE;
            y.st.esc           = ESC_NONE;
            y.st.path_nonempty = 1'b0;
         end
      endcase
      return y;
   endfunction

   // byte inside the target or a dependency, no escape open
   function automatic ctx_type path_char(ctx_type x, logic [7:0] c);
      ctx_type y;
      logic    tgt;
      y   = x;
      tgt = (y.st.phase == PH_TGT);
      if (is_eol(c)) begin
         y = finish_line(y);
      end else if (is_blank(c) || (tgt && c == CH_COLON)) begin
         if (tgt && !y.st.path_nonempty) begin
            y = stop_with(y, KIND_ERR, ERR_NO_TARGET);
         end else begin
            y = emit(y, KIND_END, 8'd0, tgt, ERR_NONE);
            y.st.path_nonempty = 1'b0;
            if (tgt && c != CH_COLON) y.st.phase = PH_AFTER;
            else                      y.st.phase = PH_GAP;
         end
      end else if (c == CH_BSL) begin
         y.st.esc = ESC_BSL;
      end else begin
         y = put_byte(y, c);
      end
      return y;
   endfunction

   function automatic ctx_type gap_char(ctx_type x, logic [7:0] c);
      ctx_type y;
      y = x;
      if (is_blank(c)) begin
         y = x;
      end else if (is_eol(c)) begin
         y = finish_line(y);
      end else if (c == CH_BSL) begin
         y.st.esc = ESC_BSL;
      end else begin
         y.st.phase = PH_DEP;
         y = path_char(y, c);
      end
      return y;
   endfunction

   function automatic ctx_type resolve_escape(ctx_type x, logic [7:0] c);
      ctx_type y;
      y = x;
      if (c == CH_LF) begin
         // line continuation joins path pieces
         y.st.esc = ESC_NONE;
         if (y.st.phase == PH_TGT)      y.st.phase = PH_TGT_SKIP;
         else if (y.st.phase == PH_DEP) y.st.phase = PH_DEP_SKIP;
      end else if (y.st.esc == ESC_BSL) begin
         if (c == CH_CR) begin
            y.st.esc = ESC_BSL_CR;
         end else begin
            y.st.esc = ESC_NONE;
            if (c == CH_SPACE || c == CH_BSL || c == CH_HASH) begin
               y = put_byte(y, c);
            end else begin
               y = put_byte(y, CH_BSL);
               y = path_char(y, c);
            end
         end
      end else begin
         // backslash-cr not followed by lf: literal backslash, cr ends the line
         y.st.esc = ESC_NONE;
         y = put_byte(y, CH_BSL);
         y = finish_line(y);
      end
      return y;
   endfunction

   function automatic ctx_type take_byte(ctx_type x, logic [7:0] c);
      ctx_type y;
      y = x;
      if (y.st.esc != ESC_NONE && y.st.phase != PH_DONE) begin
         y = resolve_escape(y, c);
      end else begin
         y.st.esc = ESC_NONE;
         unique case (y.st.phase) inside
            PH_LEAD: begin
               if (!is_blank(c)) begin
                  y.st.phase = PH_TGT;
                  y = path_char(y, c);
               end
            end
            PH_TGT, PH_DEP: y = path_char(y, c);
            PH_TGT_SKIP, PH_DEP_SKIP: begin
               if (!is_blank(c)) begin
                  y.st.phase = (y.st.phase == PH_TGT_SKIP) ? PH_TGT : PH_DEP;
                  y = path_char(y, c);
               end
            end
            PH_AFTER: begin
               if (c == CH_COLON) begin
                  y.st.phase = PH_GAP;
               end else if (!is_blank(c)) begin
                  y.st.phase = PH_GAP;
                  y = gap_char(y, c);
               end
            end
            PH_GAP: y = gap_char(y, c);
            default: y = x;
         endcase
      end
      return y;
   endfunction

   ctx_type ctx_a;
   ctx_type ctx_b;
   ctx_type ctx_c;

   always_comb begin
      ctx_a.st        = state_cur;
      ctx_a.res.count = '0;
      ctx_a.res.recs  = '0;

      ctx_b = byte_present ? take_byte(ctx_a, text_byte) : ctx_a;

      ctx_c = ctx_b;
      if (content_end) begin
         if (ctx_c.st.phase != PH_DONE) begin
            if (ctx_c.st.esc != ESC_NONE) begin
               ctx_c.st.esc = ESC_NONE;
               ctx_c = put_byte(ctx_c, CH_BSL);
            end
            ctx_c = finish_line(ctx_c);
         end
         ctx_c.st.phase         = PH_LEAD;
         ctx_c.st.esc           = ESC_NONE;
         ctx_c.st.path_nonempty = 1'b0;
      end

      if (ctx_c.res.count != '0) begin
         ctx_c.res.recs[2'(ctx_c.res.count - RES_CNT_W'(1))].last_of_run = 1'b1;
      end

      state_nxt = ctx_c.st;
      step_out  = ctx_c.res;
   end

endmodule

FILE: rtl/make_depfile_tokenizer.sv
// top level of the make-style dependency file tokenizer
//
// usage
//   req channel: one beat per content byte. req_tdata carries the byte,
//   req_tuser says whether the byte is present (0 for an end-only beat) and
//   req_tlast marks the final beat of the content, after which the parser
//   returns to its start state.
//   rsp channel: one beat per record: path byte, end of path, parse complete
//   or error. rsp_tlast marks the final record caused by one req beat; a
//   req beat may cause zero to four records.
// queue and throughput
//   the tokenizer state advances in the cycle a req beat is taken, and its
//   records are registered into an 8-entry record queue; they reach rsp
//   behind any records already waiting there. a req beat is taken every
//   cycle while the queue holds four records or fewer, so the rate is one
//   byte per cycle as long as the rsp side drains the records as fast as
//   they come; the rsp drain of one record per cycle sets the long-run limit.
// reset and stall
//   reset empties the queue and puts the parser in the leading whitespace
//   phase. when rsp_tready is low, records wait in the queue and req_tready
//   drops once more than four are waiting; nothing is lost or repeated.
module make_depfile_tokenizer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // content_end
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] path_byte, [9:8] error_code, [15:10] zero
   output logic [2:0]  rsp_tuser,   // [1:0] record_kind, [2] is_target
   output logic        rsp_tlast    // last_of_run
);
   import mdt_pkg::*;

   // tokenizer state
   state_type state_ff;
   state_type state_in;
   state_type state_nxt;
   step_type  step_res;

   // record queue, head at entry 0
   rec_type                 fifo_ff [FIFO_DEPTH];
   rec_type                 fifo_in [FIFO_DEPTH];
   logic [FIFO_CNT_W-1:0]   cnt_ff;
   logic [FIFO_CNT_W-1:0]   cnt_in;
   logic [FIFO_CNT_W-1:0]   cnt_pop;

   logic push;
   logic pop;

   mdt_step u_step (
      .state_cur    (state_ff),
      .text_byte    (req_tdata),
      .byte_present (req_tuser),
      .content_end  (req_tlast),
      .state_nxt    (state_nxt),
      .step_out     (step_res)
   );

   // room for a full burst of records from one beat
   assign req_tready = (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
   assign push       = req_tvalid && req_tready;

   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign rsp_tdata  = {6'd0, fifo_ff[0].error_code, fifo_ff[0].path_byte};
   assign rsp_tuser  = {fifo_ff[0].is_target, fifo_ff[0].record_kind};
   assign rsp_tlast  = fifo_ff[0].last_of_run;

   always_comb begin
      state_in = push ? state_nxt : state_ff;
      cnt_pop  = pop ? (cnt_ff - FIFO_CNT_W'(1)) : cnt_ff;

      // shift out the head beat
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         if (pop && i < FIFO_DEPTH - 1) fifo_in[i] = fifo_ff[i + 1];
         else                           fifo_in[i] = fifo_ff[i];
      end

      // append the new records behind what stays
      if (push) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (RES_CNT_W'(j) < step_res.count) begin
               fifo_in[FIFO_IDX_W'(cnt_pop + FIFO_CNT_W'(j))] = step_res.recs[j];
            end
         end
         cnt_in = cnt_pop + FIFO_CNT_W'(step_res.count);
      end else begin
         cnt_in = cnt_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_LEAD;
         state_ff.esc           <= ESC_NONE;
         state_ff.path_nonempty <= 1'b0;
         cnt_ff                 <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

   // queue never overflows its entries
   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("record queue count out of range");

   // an open escape never survives into the done phase
   a_esc_done : assert property (@(posedge clock) disable iff (reset)
      state_ff.esc != ESC_NONE |-> state_ff.phase != PH_DONE)
      else $error("escape pending after parse end");

   // end of content always returns the parser to its start state
   a_end_resets : assert property (@(posedge clock) disable iff (reset)
      push && req_tlast |=> state_ff.phase == PH_LEAD && state_ff.esc == ESC_NONE
                            && !state_ff.path_nonempty)
      else $error("parser not reset after content end");

   // a path byte was seen only while inside a path
   a_nonempty_phase : assert property (@(posedge clock) disable iff (reset)
      state_ff.path_nonempty |-> state_ff.phase == PH_TGT || state_ff.phase == PH_TGT_SKIP
                                 || state_ff.phase == PH_DEP
                                 || state_ff.phase == PH_DEP_SKIP)
      else $error("path marked nonempty outside a path");

   // target flag only on byte and end records
   a_target_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == KIND_BYTE
                                     || rsp_tuser[1:0] == KIND_END)
      else $error("target flag on a done or error record");

endmodule
